// File: hw/rtl/q30fa_pkg.sv
// ----------------------------------------------------------------------------
// q30fa_pkg: shared definitions for the Q30 fraction ALU
// Operation codes, default word width and the control bundle that travels
// with each request through the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package q30fa_pkg;

    // default fraction word width (sign bit included)
    localparam int WORD_BITS_DEF = 31;

    // operation codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // control bundle carried along every stage
    typedef struct packed {
        op_t  op;
        logic neg;   // product sign for multiply
    } ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/q30fa_prep.sv
// ----------------------------------------------------------------------------
// q30fa_prep: operand preparation stage
// Computes add and subtract results, turns multiply operands into magnitudes
// with a product sign, and loads the divide remainder and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module q30fa_prep #(
    parameter int WORD_BITS = q30fa_pkg::WORD_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire q30fa_pkg::op_t          in_op,
    input  wire [WORD_BITS-1:0]          in_a,
    input  wire [WORD_BITS-1:0]          in_b,
    output logic                         out_valid,
    input  wire                          out_ready,
    output q30fa_pkg::ctl_t              out_ctl,
    output logic [WORD_BITS-1:0]         out_acc,
    output logic [WORD_BITS-1:0]         out_aux,
    output logic [WORD_BITS-1:0]         out_y
);

    logic                    valid_reg;
    q30fa_pkg::ctl_t         ctl_reg;
    q30fa_pkg::ctl_t         ctl_next;
    logic [WORD_BITS-1:0]    acc_reg;
    logic [WORD_BITS-1:0]    acc_next;
    logic [WORD_BITS-1:0]    aux_reg;
    logic [WORD_BITS-1:0]    aux_next;
    logic [WORD_BITS-1:0]    y_reg;
    logic [WORD_BITS-1:0]    y_next;
    logic [WORD_BITS-1:0]    mag_a;
    logic [WORD_BITS-1:0]    mag_b;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // take magnitudes of the multiply operands
    assign mag_a = in_a[WORD_BITS-1] ? (~in_a + WORD_BITS'(1)) : in_a;
    assign mag_b = in_b[WORD_BITS-1] ? (~in_b + WORD_BITS'(1)) : in_b;

    // set up the working fields for each operation
    always_comb
    begin
        ctl_next.op  = in_op;
        ctl_next.neg = in_a[WORD_BITS-1] ^ in_b[WORD_BITS-1];
        acc_next     = '0;
        aux_next     = '0;
        y_next       = in_b;
        unique case (in_op)
            q30fa_pkg::OP_ADD:
            begin
                acc_next = in_a + in_b;
            end
            q30fa_pkg::OP_SUB:
            begin
                acc_next = in_a - in_b;
            end
            q30fa_pkg::OP_MUL:
            begin
                aux_next = mag_a;
                y_next   = mag_b;
            end
            q30fa_pkg::OP_DIV:
            begin
                acc_next = in_a;
            end
            default:
            begin
                acc_next = '0;
            end
        endcase
    end

    // hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= ctl_next;
            acc_reg <= acc_next;
            aux_reg <= aux_next;
            y_reg   <= y_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_acc   = acc_reg;
    assign out_aux   = aux_reg;
    assign out_y     = y_reg;

endmodule

`default_nettype wire

// File: hw/rtl/q30fa_step.sv
// ----------------------------------------------------------------------------
// q30fa_step: one shift-add or non-restoring divide step
// Multiply adds the multiplicand when multiplier bit STEP is set and shifts
// the partial product right; divide forms 2r +/- d and sets a quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module q30fa_step #(
    parameter int WORD_BITS = q30fa_pkg::WORD_BITS_DEF,
    parameter int STEP      = 0
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire q30fa_pkg::ctl_t         in_ctl,
    input  wire [WORD_BITS-1:0]          in_acc,
    input  wire [WORD_BITS-1:0]          in_aux,
    input  wire [WORD_BITS-1:0]          in_y,
    output logic                         out_valid,
    input  wire                          out_ready,
    output q30fa_pkg::ctl_t              out_ctl,
    output logic [WORD_BITS-1:0]         out_acc,
    output logic [WORD_BITS-1:0]         out_aux,
    output logic [WORD_BITS-1:0]         out_y
);

    localparam logic [WORD_BITS-1:0] BIT_POS = WORD_BITS'(1) << (WORD_BITS - 1 - STEP);

    logic                    valid_reg;
    q30fa_pkg::ctl_t         ctl_reg;
    logic [WORD_BITS-1:0]    acc_reg;
    logic [WORD_BITS-1:0]    acc_next;
    logic [WORD_BITS-1:0]    aux_reg;
    logic [WORD_BITS-1:0]    aux_next;
    logic [WORD_BITS-1:0]    y_reg;
    logic [WORD_BITS-1:0]    mul_sum;
    logic [WORD_BITS-1:0]    rem_dbl;
    logic                    same_sign;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // partial product add and remainder doubling
    assign mul_sum   = in_aux[STEP] ? (in_acc + in_y) : in_acc;
    assign rem_dbl   = {in_acc[WORD_BITS-2:0], 1'b0};
    assign same_sign = (in_acc[WORD_BITS-1] == in_y[WORD_BITS-1]);

    // advance the item by one step; add and subtract pass through
    always_comb
    begin
        acc_next = in_acc;
        aux_next = in_aux;
        unique case (in_ctl.op)
            q30fa_pkg::OP_MUL:
            begin
                acc_next = {1'b0, mul_sum[WORD_BITS-1:1]};
            end
            q30fa_pkg::OP_DIV:
            begin
                if (same_sign)
                begin
                    acc_next = rem_dbl - in_y;
                    aux_next = in_aux | BIT_POS;
                end
                else
                begin
                    acc_next = rem_dbl + in_y;
                end
            end
            default:
            begin
                acc_next = in_acc;
            end
        endcase
    end

    // hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // capture the stepped item
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg <= in_ctl;
            acc_reg <= acc_next;
            aux_reg <= aux_next;
            y_reg   <= in_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_acc   = acc_reg;
    assign out_aux   = aux_reg;
    assign out_y     = y_reg;

endmodule

`default_nettype wire

// File: hw/rtl/q30fa_final.sv
// ----------------------------------------------------------------------------
// q30fa_final: result formatting and output register
// Restores the product sign and sets the rounding bit, applies the quotient
// correction, and holds the result word for the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module q30fa_final #(
    parameter int WORD_BITS = q30fa_pkg::WORD_BITS_DEF
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire q30fa_pkg::ctl_t         in_ctl,
    input  wire [WORD_BITS-1:0]          in_acc,
    input  wire [WORD_BITS-1:0]          in_aux,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [WORD_BITS-1:0]         out_result
);

    localparam logic [WORD_BITS-1:0] WORD_MSB = WORD_BITS'(1) << (WORD_BITS - 1);

    logic                    valid_reg;
    logic [WORD_BITS-1:0]    result_reg;
    logic [WORD_BITS-1:0]    result_next;
    logic [WORD_BITS-1:0]    prod;
    logic                    load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // signed product before the rounding bit
    assign prod = in_ctl.neg ? (~in_acc + WORD_BITS'(1)) : in_acc;

    // format the result word
    always_comb
    begin
        unique case (in_ctl.op)
            q30fa_pkg::OP_ADD,
            q30fa_pkg::OP_SUB:
            begin
                result_next = in_acc;
            end
            q30fa_pkg::OP_MUL:
            begin
                result_next = prod | WORD_BITS'(1);
            end
            q30fa_pkg::OP_DIV:
            begin
                result_next = in_aux + WORD_MSB + WORD_BITS'(1);
            end
            default:
            begin
                result_next = in_acc;
            end
        endcase
    end

    // hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // capture the result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/q30_fraction_alu_core.sv
// Stages from request to result: one preparation stage, WORD_BITS - 1 step
//   stages of one shift-add or divide step each, one output stage.
// Throughput: one request per cycle while m_tready is high; every stage
//   advances on its own when the next has room.
// Reset: rst_n clears all valid bits at once; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
// q30_fraction_alu_core: pipelined fraction ALU
// Add, subtract, sign-magnitude multiply and non-restoring divide on
// two's complement fractions, one result per request.
// ----------------------------------------------------------------------------
`default_nettype none

module q30_fraction_alu_core #(
    parameter int WORD_BITS = q30fa_pkg::WORD_BITS_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // fields from bit 0: req_type (2), operand_a (WORD_BITS), operand_b (WORD_BITS)
    input  wire [((2*WORD_BITS+2+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // fields from bit 0: result_word (WORD_BITS)
    output logic [((WORD_BITS+7)/8)*8-1:0]    m_tdata
);

    localparam int STEPS    = WORD_BITS - 1;
    localparam int OUT_BITS = ((WORD_BITS + 7) / 8) * 8;
    localparam int DEPTH    = WORD_BITS + 1;
    localparam int OCC_BITS = $clog2(DEPTH + 1);

    // stage boundaries: index 0 leaves preparation, index k+1 leaves step k
    logic                    st_valid [0:STEPS];
    logic                    st_ready [0:STEPS];
    q30fa_pkg::ctl_t         st_ctl   [0:STEPS];
    logic [WORD_BITS-1:0]    st_acc   [0:STEPS];
    logic [WORD_BITS-1:0]    st_aux   [0:STEPS];
    logic [WORD_BITS-1:0]    st_y     [0:STEPS];
    logic [WORD_BITS-1:0]    result;
    q30fa_pkg::op_t          req_op;

    assign req_op = q30fa_pkg::op_t'(s_tdata[1:0]);

    // unpack the request and prepare operands
    q30fa_prep #(
        .WORD_BITS (WORD_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (req_op),
        .in_a      (s_tdata[WORD_BITS+1:2]),
        .in_b      (s_tdata[2*WORD_BITS+1:WORD_BITS+2]),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_ctl   (st_ctl[0]),
        .out_acc   (st_acc[0]),
        .out_aux   (st_aux[0]),
        .out_y     (st_y[0])
    );

    // one stage per multiply or divide step
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        q30fa_step #(
            .WORD_BITS (WORD_BITS),
            .STEP      (k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_ctl    (st_ctl[k]),
            .in_acc    (st_acc[k]),
            .in_aux    (st_aux[k]),
            .in_y      (st_y[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_ctl   (st_ctl[k+1]),
            .out_acc   (st_acc[k+1]),
            .out_aux   (st_aux[k+1]),
            .out_y     (st_y[k+1])
        );
    end

    // format and hold the result
    q30fa_final #(
        .WORD_BITS (WORD_BITS)
    ) u_final (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (st_valid[STEPS]),
        .in_ready   (st_ready[STEPS]),
        .in_ctl     (st_ctl[STEPS]),
        .in_acc     (st_acc[STEPS]),
        .in_aux     (st_aux[STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = OUT_BITS'(result);

    // track requests in flight for the checks below
    logic [OCC_BITS-1:0] occ_reg;
    logic [OCC_BITS-1:0] occ_next;
    logic                in_fire;
    logic                out_fire;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    always_comb
    begin
        occ_next = occ_reg;
        if (in_fire && !out_fire)
        begin
            occ_next = occ_reg + OCC_BITS'(1);
        end
        else if (out_fire && !in_fire)
        begin
            occ_next = occ_reg - OCC_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // never more requests in flight than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_BITS'(DEPTH))
        else $error("pipeline holds more requests than stages");

    // a result only appears for a request that was taken
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (occ_reg != '0))
        else $error("result presented with nothing in flight");

    // input back-pressure only when the output side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request refused while output side is free");

    // a full pipeline refuses new requests
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == OCC_BITS'(DEPTH)) && !m_tready |-> !s_tready)
        else $error("request taken into a full pipeline");

endmodule

`default_nettype wire

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for q30_fraction_alu_core
// Runs a table of directed requests, then about a thousand random add,
// subtract, multiply and divide requests. Random stalls are applied on both
// stream sides. Each result is checked in order against a table value or a
// bit-exact predictor of the fraction arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int WB        = q30fa_pkg::WORD_BITS_DEF;
    localparam int S_W       = ((2*WB+2+7)/8)*8;
    localparam int M_W       = ((WB+7)/8)*8;
    localparam int NUM_ROWS  = 22;
    localparam int NUM_RAND  = 1080;
    localparam int CALM_TAIL = 150;
    localparam int DRAIN_CYC = WB + 9;
    localparam int STALL_MAX = 2000;

    typedef logic [WB-1:0] word_t;

    localparam word_t WORD_MSB = {1'b1, {(WB-1){1'b0}}};
    localparam word_t MAX_POS  = ~WORD_MSB;
    localparam word_t ALL_ONES = '1;

    typedef struct {
        q30fa_pkg::op_t op;
        word_t          a;
        word_t          b;
    } alu_req_t;

    typedef struct {
        q30fa_pkg::op_t op;
        word_t          a;
        word_t          b;
        bit             known;
        word_t          res;
    } stim_row_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;

    word_t     pending_words[$];
    int        mismatches;
    bit        calm;
    stim_row_t directed_rows [NUM_ROWS];

    q30_fraction_alu_core #(
        .WORD_BITS(WB)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // fraction arithmetic predictor
    // ------------------------------------------------------------------
    function automatic word_t twos_neg(word_t v);
        return ~v + 1'b1;
    endfunction

    // sign-magnitude shift-add; mplier bits are examined from bit 0
    function automatic word_t fraction_product(word_t mplier, word_t mcand);
        logic  neg;
        word_t acc;
        neg = mplier[WB-1] ^ mcand[WB-1];
        acc = '0;
        if (mplier[WB-1])
            mplier = twos_neg(mplier);
        if (mcand[WB-1])
            mcand = twos_neg(mcand);
        for (int k = 0; k < WB-1; k++)
        begin
            if (mplier[0])
                acc = acc + mcand;
            mplier = mplier >> 1;
            acc    = acc >> 1;
        end
        if (neg)
            acc = twos_neg(acc);
        acc[0] = 1'b1;
        return acc;
    endfunction

    // non-restoring steps on sign comparison, then fixed correction
    function automatic word_t fraction_quotient(word_t rem, word_t dvs);
        word_t quo;
        word_t bitmask;
        quo     = '0;
        bitmask = WORD_MSB;
        for (int k = 0; k < WB-1; k++)
        begin
            if (rem[WB-1] != dvs[WB-1])
                rem = (rem << 1) + dvs;
            else
            begin
                rem = (rem << 1) - dvs;
                quo = quo | bitmask;
            end
            bitmask = bitmask >> 1;
        end
        return quo + WORD_MSB + 1'b1;
    endfunction

    function automatic word_t alu_result(alu_req_t r);
        case (r.op)
            q30fa_pkg::OP_ADD: return r.a + r.b;
            q30fa_pkg::OP_SUB: return r.a + twos_neg(r.b);
            q30fa_pkg::OP_MUL: return fraction_product(r.a, r.b);
            default:           return fraction_quotient(r.a, r.b);
        endcase
    endfunction

    function automatic logic [S_W-1:0] pack_request(alu_req_t r);
        logic [S_W-1:0] v;
        v               = '0;
        v[1:0]          = r.op;
        v[WB+1:2]       = r.a;
        v[2*WB+1:WB+2]  = r.b;
        return v;
    endfunction

    // bias toward the corners of the fraction range
    function automatic word_t pick_operand();
        word_t v;
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = MAX_POS;
            2:       v = WORD_MSB;
            3:       v = ALL_ONES;
            4:       v = word_t'(1);
            5:       v = word_t'($urandom_range(0, 255));
            6:       v = twos_neg(word_t'($urandom_range(1, 255)));
            default: v = word_t'($urandom);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    task automatic push_request(alu_req_t r, bit known, word_t typed);
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_words.push_back(known ? typed : alu_result(r));
    endtask

    // drop valid for a random burst now and then
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // hold off new requests until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side: stall in random bursts until the calm tail
    // ------------------------------------------------------------------
    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // check each returned word against the oldest expectation
    always @(posedge clk)
    begin : check_results
        logic [M_W-1:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want         = '0;
                want[WB-1:0] = pending_words.pop_front();
                if (m_tdata !== want)
                begin
                    mismatches++;
                    $display("%0t: result_word mismatch, expected %h, actual %h",
                             $time, want, m_tdata);
                end
            end
        end
    end

    // end the run if nothing moves for too long
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_MAX)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall = 0;
            else
                stall++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        alu_req_t r;
        mismatches = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;

        directed_rows = '{
            // wraparound on add and subtract
            '{q30fa_pkg::OP_ADD, 31'h00000000, 31'h00000000, 1'b1, 31'h00000000},
            '{q30fa_pkg::OP_ADD, 31'h3FFFFFFF, 31'h00000001, 1'b1, 31'h40000000},
            '{q30fa_pkg::OP_ADD, 31'h7FFFFFFF, 31'h00000001, 1'b1, 31'h00000000},
            '{q30fa_pkg::OP_ADD, 31'h40000000, 31'h40000000, 1'b1, 31'h00000000},
            '{q30fa_pkg::OP_SUB, 31'h00000000, 31'h00000001, 1'b1, 31'h7FFFFFFF},
            '{q30fa_pkg::OP_SUB, 31'h40000000, 31'h00000001, 1'b1, 31'h3FFFFFFF},
            '{q30fa_pkg::OP_SUB, 31'h3FFFFFFF, 31'h7FFFFFFF, 1'b1, 31'h40000000},
            // zero product and most negative multiplier give the rounding bit
            '{q30fa_pkg::OP_MUL, 31'h00000000, 31'h00000000, 1'b1, 31'h00000001},
            '{q30fa_pkg::OP_MUL, 31'h40000000, 31'h3FFFFFFF, 1'b1, 31'h00000001},
            '{q30fa_pkg::OP_MUL, 31'h40000000, 31'h40000000, 1'b1, 31'h00000001},
            '{q30fa_pkg::OP_MUL, 31'h3FFFFFFF, 31'h00000000, 1'b1, 31'h00000001},
            '{q30fa_pkg::OP_MUL, 31'h3FFFFFFF, 31'h3FFFFFFF, 1'b0, 31'h0},
            // most negative multiplicand acts as magnitude one
            '{q30fa_pkg::OP_MUL, 31'h20000000, 31'h40000000, 1'b0, 31'h0},
            '{q30fa_pkg::OP_MUL, 31'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, 31'h0},
            '{q30fa_pkg::OP_MUL, 31'h60000000, 31'h20000000, 1'b0, 31'h0},
            // divide by zero runs the steps unchanged
            '{q30fa_pkg::OP_DIV, 31'h00000000, 31'h00000000, 1'b0, 31'h0},
            '{q30fa_pkg::OP_DIV, 31'h10000000, 31'h00000000, 1'b0, 31'h0},
            '{q30fa_pkg::OP_DIV, 31'h10000000, 31'h20000000, 1'b0, 31'h0},
            // quotient overflow is not flagged
            '{q30fa_pkg::OP_DIV, 31'h3FFFFFFF, 31'h00000001, 1'b0, 31'h0},
            '{q30fa_pkg::OP_DIV, 31'h40000000, 31'h7FFFFFFF, 1'b0, 31'h0},
            '{q30fa_pkg::OP_DIV, 31'h70000000, 31'h20000000, 1'b0, 31'h0},
            '{q30fa_pkg::OP_DIV, 31'h7FFFFFFF, 31'h40000000, 1'b0, 31'h0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            r.op = directed_rows[i].op;
            r.a  = directed_rows[i].a;
            r.b  = directed_rows[i].b;
            push_request(r, directed_rows[i].known, directed_rows[i].res);
            maybe_gap();
        end
        drain_results();

        // random requests; pause once mid-run and go calm at the tail
        for (int i = 0; i < NUM_RAND; i++)
        begin
            if (i == NUM_RAND / 2)
                drain_results();
            if (i == NUM_RAND - CALM_TAIL)
                calm = 1'b1;
            r.op = q30fa_pkg::op_t'($urandom_range(0, 3));
            r.a  = pick_operand();
            r.b  = pick_operand();
            push_request(r, 1'b0, '0);
            maybe_gap();
        end

        drain_results();
        repeat (DRAIN_CYC) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/q30fa_pkg.sv
hw/rtl/q30fa_prep.sv
hw/rtl/q30fa_step.sv
hw/rtl/q30fa_final.sv
hw/rtl/q30_fraction_alu_core.sv
test/tb.sv
